// ----- sv/cic_decimator_macros.svh -----
// Assertion macros shared by the CIC decimator RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef CIC_DECIMATOR_MACROS_SVH
`define CIC_DECIMATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CIC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cic_decimator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CIC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cic_decimator: next-cycle check failed");

`endif

// ----- sv/cic_pkg.sv -----
// Package for the CIC decimator: default sizes, register map and pipeline control type.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cic_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_MAX_ORDER    = 5;
    localparam int DEF_MAX_RATE     = 64;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_ACC_WIDTH    = 51;

    // Configuration register map.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int ORDER_W     = 3;
    localparam int RATE_REG_W  = 7;
    localparam int DELAY_W     = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_STAGE_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECIM_RATE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DIFF_DELAY   = 2'd2;

    localparam logic [ORDER_W-1:0]    RST_STAGE_COUNT = 3'd1;
    localparam logic [RATE_REG_W-1:0] RST_DECIM_RATE  = 7'd2;
    localparam logic [DELAY_W-1:0]    RST_DIFF_DELAY  = 2'd1;

    // Smallest decimation rate the filter runs at.
    localparam int MIN_RATE = 2;

    // Control that travels with each sample down the pipeline.
    typedef struct packed {
        logic valid;
        logic block_start;
        logic emit;
    } ctrl_t;

endpackage

// ----- sv/cic_decimator.sv -----
// CIC decimator: one sample per cycle in while the output is not stalled, one result per
// decimated sample out. Every integrator and comb stage has its own register, so a sample
// can be accepted in every cycle unless m_ready holds the pipeline back. A sample passes the
// input register, each integrator register and each comb register in turn. Stages beyond
// the configured order pass data through, so latency does not depend on the order. A sample
// with block_start set clears the integrators, comb delays and phase and is always emitted.
// A write to a mapped register clears the same state. No clearing pass follows reset.
// Depends on cic_pkg, cic_integrator, cic_comb and cic_decimator_macros.svh.
`timescale 1ns / 1ps
`include "cic_decimator_macros.svh"

module cic_decimator #(
    parameter int MAX_ORDER    = cic_pkg::DEF_MAX_ORDER,
    parameter int MAX_RATE     = cic_pkg::DEF_MAX_RATE,
    parameter int SAMPLE_WIDTH = cic_pkg::DEF_SAMPLE_WIDTH,
    parameter int ACC_WIDTH    = cic_pkg::DEF_ACC_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [cic_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cic_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_sample,
    input  logic                                s_block_start,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ACC_WIDTH-1:0]         m_filtered
);
    import cic_pkg::*;

    localparam int PHASE_W = (MAX_RATE > 2) ? $clog2(MAX_RATE) : 1;
    localparam int CNT_W   = PHASE_W + 1;

    // Configuration registers.
    logic [ORDER_W-1:0]    stage_count_reg;
    logic [RATE_REG_W-1:0] decim_rate_reg;
    logic [DELAY_W-1:0]    diff_delay_reg;
    logic                  cfg_clear;

    // Input register and decimation phase.
    ctrl_t                in_ctrl_reg;
    logic [ACC_WIDTH-1:0] in_data_reg;
    logic [PHASE_W-1:0]   phase_reg;
    logic [PHASE_W-1:0]   phase_base;
    logic [PHASE_W-1:0]   phase_next;
    logic [CNT_W-1:0]     phase_inc;
    logic [CNT_W-1:0]     rate_eff;
    logic                 emit_now;
    logic                 delay_two;
    logic [MAX_ORDER-1:0] stage_en;

    // Stage chain: index i feeds stage i.
    ctrl_t                int_ctrl  [MAX_ORDER+1];
    logic [ACC_WIDTH-1:0] int_data  [MAX_ORDER+1];
    logic                 int_ready [MAX_ORDER+1];
    ctrl_t                comb_ctrl [MAX_ORDER+1];
    logic [ACC_WIDTH-1:0] comb_data [MAX_ORDER+1];
    logic                 comb_ready[MAX_ORDER+1];

    // Register decode; an index beyond the map is ignored.
    always_comb begin
        unique case (cfg_index)
            REG_STAGE_COUNT,
            REG_DECIM_RATE,
            REG_DIFF_DELAY: cfg_clear = cfg_wr_en;
            default:        cfg_clear = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_count_reg <= RST_STAGE_COUNT;
            decim_rate_reg  <= RST_DECIM_RATE;
            diff_delay_reg  <= RST_DIFF_DELAY;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STAGE_COUNT: stage_count_reg <= cfg_data[ORDER_W-1:0];
                REG_DECIM_RATE:  decim_rate_reg  <= cfg_data[RATE_REG_W-1:0];
                REG_DIFF_DELAY:  diff_delay_reg  <= cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective settings, clamped to the supported range.
    always_comb begin
        if (int'(decim_rate_reg) < MIN_RATE) begin
            rate_eff = CNT_W'(MIN_RATE);
        end else if (int'(decim_rate_reg) > MAX_RATE) begin
            rate_eff = CNT_W'(MAX_RATE);
        end else begin
            rate_eff = CNT_W'(decim_rate_reg);
        end
        delay_two = (diff_delay_reg >= 2'd2);
        for (int s = 0; s < MAX_ORDER; s++) begin
            stage_en[s] = (s == 0) || (int'(stage_count_reg) > s);
        end
    end

    // Phase counter: a result is due when the phase is zero.
    always_comb begin
        phase_base = s_block_start ? '0 : phase_reg;
        emit_now   = (phase_base == '0);
        phase_inc  = CNT_W'(phase_base) + CNT_W'(1);
        phase_next = (phase_inc >= rate_eff) ? '0 : phase_inc[PHASE_W-1:0];
        s_ready    = !in_ctrl_reg.valid || int_ready[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            in_ctrl_reg <= '0;
        end else begin
            if (cfg_clear) begin
                phase_reg <= '0;
            end else if (s_valid && s_ready) begin
                phase_reg <= phase_next;
            end
            if (s_ready) begin
                in_ctrl_reg <= '{valid: s_valid, block_start: s_block_start, emit: emit_now};
            end
        end
    end

    // The sample is sign-extended to accumulator width on the way in.
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_data_reg <= ACC_WIDTH'(s_sample);
        end
    end

    assign int_ctrl[0] = in_ctrl_reg;
    assign int_data[0] = in_data_reg;

    // Integrator cascade.
    for (genvar s = 0; s < MAX_ORDER; s++) begin : g_integ
        cic_integrator #(
            .ACC_WIDTH(ACC_WIDTH)
        ) u_integ (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .clear    (cfg_clear),
            .stage_en (stage_en[s]),
            .in_ctrl  (int_ctrl[s]),
            .in_data  (int_data[s]),
            .in_ready (int_ready[s]),
            .out_ctrl (int_ctrl[s+1]),
            .out_data (int_data[s+1]),
            .out_ready(int_ready[s+1])
        );
    end

    // Samples that are not decimated are dropped between the two cascades.
    assign int_ready[MAX_ORDER] = comb_ready[0] || !int_ctrl[MAX_ORDER].emit;
    assign comb_ctrl[0] = '{valid:       int_ctrl[MAX_ORDER].valid && int_ctrl[MAX_ORDER].emit,
                            block_start: int_ctrl[MAX_ORDER].block_start,
                            emit:        int_ctrl[MAX_ORDER].emit};
    assign comb_data[0] = int_data[MAX_ORDER];

    // Comb cascade at the decimated rate.
    for (genvar s = 0; s < MAX_ORDER; s++) begin : g_comb
        cic_comb #(
            .ACC_WIDTH(ACC_WIDTH)
        ) u_comb (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .clear    (cfg_clear),
            .stage_en (stage_en[s]),
            .delay_two(delay_two),
            .in_ctrl  (comb_ctrl[s]),
            .in_data  (comb_data[s]),
            .in_ready (comb_ready[s]),
            .out_ctrl (comb_ctrl[s+1]),
            .out_data (comb_data[s+1]),
            .out_ready(comb_ready[s+1])
        );
    end

    // The last comb register is the result register.
    assign comb_ready[MAX_ORDER] = m_ready;
    assign m_valid    = comb_ctrl[MAX_ORDER].valid;
    assign m_filtered = comb_data[MAX_ORDER];

    // Checks on phase tracking and input flow.
    `CIC_ASSERT_IMP(a_phase_range, aclk, aresetn, 1'b1, (CNT_W'(phase_reg) < rate_eff))
    `CIC_ASSERT_NXT(a_start_emits, aclk, aresetn, s_valid && s_ready && s_block_start,
                    in_ctrl_reg.valid && in_ctrl_reg.emit)
    `CIC_ASSERT_NXT(a_cfg_clears_phase, aclk, aresetn, cfg_clear, phase_reg == '0)
    `CIC_ASSERT_IMP(a_empty_input_ready, aclk, aresetn, !in_ctrl_reg.valid, s_ready)

endmodule

// ----- sv/cic_integrator.sv -----
// One integrator stage of the CIC decimator, with its own output register.
// Depends on cic_pkg for the pipeline control type.
`timescale 1ns / 1ps

module cic_integrator #(
    parameter int ACC_WIDTH = cic_pkg::DEF_ACC_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear,
    input  logic                 stage_en,
    input  cic_pkg::ctrl_t       in_ctrl,
    input  logic [ACC_WIDTH-1:0] in_data,
    output logic                 in_ready,
    output cic_pkg::ctrl_t       out_ctrl,
    output logic [ACC_WIDTH-1:0] out_data,
    input  logic                 out_ready
);
    import cic_pkg::*;

    ctrl_t                out_ctrl_reg;
    logic [ACC_WIDTH-1:0] out_data_reg;
    logic [ACC_WIDTH-1:0] sum_reg;
    logic [ACC_WIDTH-1:0] sum_next;
    logic                 take;

    // The stage loads whenever its output register is free or being drained.
    always_comb begin
        in_ready = !out_ctrl_reg.valid || out_ready;
        take     = in_ctrl.valid && in_ready;
        sum_next = (in_ctrl.block_start ? '0 : sum_reg) + in_data;
    end

    // Accumulator and control; a block start restarts the sum from zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_ctrl_reg <= '0;
            sum_reg      <= '0;
        end else begin
            if (clear) begin
                sum_reg <= '0;
            end else if (take && stage_en) begin
                sum_reg <= sum_next;
            end
            if (in_ready) begin
                out_ctrl_reg <= in_ctrl;
            end
        end
    end

    // A stage beyond the configured order passes its input through.
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            out_data_reg <= stage_en ? sum_next : in_data;
        end
    end

    assign out_ctrl = out_ctrl_reg;
    assign out_data = out_data_reg;

endmodule

// ----- sv/cic_comb.sv -----
// One comb stage of the CIC decimator with a two-tap delay line and output register.
// Depends on cic_pkg for the pipeline control type.
`timescale 1ns / 1ps

module cic_comb #(
    parameter int ACC_WIDTH = cic_pkg::DEF_ACC_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear,
    input  logic                 stage_en,
    input  logic                 delay_two,
    input  cic_pkg::ctrl_t       in_ctrl,
    input  logic [ACC_WIDTH-1:0] in_data,
    output logic                 in_ready,
    output cic_pkg::ctrl_t       out_ctrl,
    output logic [ACC_WIDTH-1:0] out_data,
    input  logic                 out_ready
);
    import cic_pkg::*;

    ctrl_t                out_ctrl_reg;
    logic [ACC_WIDTH-1:0] out_data_reg;
    logic [ACC_WIDTH-1:0] tap0_reg;
    logic [ACC_WIDTH-1:0] tap1_reg;
    logic [ACC_WIDTH-1:0] tap0_base;
    logic [ACC_WIDTH-1:0] tap1_base;
    logic [ACC_WIDTH-1:0] prev;
    logic [ACC_WIDTH-1:0] diff;
    logic                 take;

    // Pick the delayed sample; a block start sees an all-zero delay line.
    always_comb begin
        in_ready  = !out_ctrl_reg.valid || out_ready;
        take      = in_ctrl.valid && in_ready;
        tap0_base = in_ctrl.block_start ? '0 : tap0_reg;
        tap1_base = in_ctrl.block_start ? '0 : tap1_reg;
        prev      = delay_two ? tap1_base : tap0_base;
        diff      = in_data - prev;
    end

    // Delay line shifts only on decimated samples that reach this stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_ctrl_reg <= '0;
            tap0_reg     <= '0;
            tap1_reg     <= '0;
        end else begin
            if (clear) begin
                tap0_reg <= '0;
                tap1_reg <= '0;
            end else if (take && stage_en) begin
                tap0_reg <= in_data;
                tap1_reg <= delay_two ? tap0_base : tap1_base;
            end
            if (in_ready) begin
                out_ctrl_reg <= in_ctrl;
            end
        end
    end

    // Output data; a stage beyond the configured order passes through.
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            out_data_reg <= stage_en ? diff : in_data;
        end
    end

    assign out_ctrl = out_ctrl_reg;
    assign out_data = out_data_reg;

endmodule
